@@ design/htx_pkg.sv @@
package htx_pkg;

    localparam int unsigned HEAD_LEN = 9;

    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_TAG  = 2'd1;
    localparam logic [1:0] MODE_RAW  = 2'd2;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef logic [HEAD_LEN-1:0][7:0] t_head;
    typedef logic [8*HEAD_LEN-1:0]    t_pat;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [3:0] drop;
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [1:0] mode;
        logic       rs;
        logic       brk;
        logic       pend;
    } t_dec;

    function automatic logic [7:0] fold(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // pattern is right-aligned in p, length = number of nonzero bytes
    function automatic logic hm(input t_head h, input t_pat p, input logic f);
        logic       ok;
        logic [7:0] c;
        int         len;
        ok  = 1'b1;
        len = 0;
        for (int i = 0; i < HEAD_LEN; i++) begin
            if (p[8*i +: 8] != 8'd0) len = len + 1;
        end
        for (int i = 0; i < HEAD_LEN; i++) begin
            if (i < len) begin
                c = f ? fold(h[i]) : h[i];
                if (c != p[8*(len-1-i) +: 8]) ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic is_tag(input t_head h);
        logic r;
        r = hm(h, "&lt;", 1'b1)
          | hm(h, "<u", 1'b1)     | hm(h, "<s", 1'b1)     | hm(h, "<b", 1'b1)
          | hm(h, "<h", 1'b1)     | hm(h, "<a", 1'b1)     | hm(h, "<p", 1'b1)
          | hm(h, "<!", 1'b1)     | hm(h, "<i", 1'b1)     | hm(h, "<d", 1'b1)
          | hm(h, "<pre", 1'b1)   | hm(h, "<mar", 1'b1)   | hm(h, "<frame", 1'b1)
          | hm(h, "<no", 1'b1)    | hm(h, "<map", 1'b1)   | hm(h, "<th", 1'b1)
          | hm(h, "<text", 1'b1)  | hm(h, "<lay", 1'b1)   | hm(h, "<li", 1'b1)
          | hm(h, "<opti", 1'b1)  | hm(h, "<tbody", 1'b1) | hm(h, "<objec", 1'b1)
          | hm(h, "<embed", 1'b1) | hm(h, "<meta", 1'b1)  | hm(h, "<titl", 1'b1)
          | hm(h, "<font", 1'b1)  | hm(h, "<tabl", 1'b1)  | hm(h, "<cent", 1'b1)
          | hm(h, "<form", 1'b1)  | hm(h, "<tr", 1'b1)    | hm(h, "<td", 1'b1)
          | hm(h, "<em", 1'b1)    | hm(h, "<labe", 1'b1)
          | hm(h, "</u", 1'b1)    | hm(h, "</s", 1'b1)    | hm(h, "</b", 1'b1)
          | hm(h, "</a", 1'b1)    | hm(h, "</p", 1'b1)    | hm(h, "</i", 1'b1)
          | hm(h, "</d", 1'b1)    | hm(h, "</h", 1'b1)    | hm(h, "</no", 1'b1)
          | hm(h, "</pre", 1'b1)  | hm(h, "</mar", 1'b1)  | hm(h, "</map", 1'b1)
          | hm(h, "</lay", 1'b1)  | hm(h, "</li", 1'b1)   | hm(h, "</th", 1'b1)
          | hm(h, "</tex", 1'b1)  | hm(h, "</opt", 1'b1)  | hm(h, "</tbod", 1'b1)
          | hm(h, "</obje", 1'b1) | hm(h, "</embe", 1'b1) | hm(h, "</meta", 1'b1)
          | hm(h, "</titl", 1'b1) | hm(h, "</font", 1'b1) | hm(h, "</tabl", 1'b1)
          | hm(h, "</cent", 1'b1) | hm(h, "</form", 1'b1) | hm(h, "</tr", 1'b1)
          | hm(h, "</td", 1'b1)   | hm(h, "</em", 1'b1)   | hm(h, "</labe", 1'b1);
        return r;
    endfunction

endpackage

@@ design/htx_if.sv @@
interface htx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface htx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       text_last;

    modport source (output valid, output text_byte, output text_last, input ready);
    modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

@@ design/htx_decide.sv @@
module htx_decide
    import htx_pkg::*;
(
    input  t_head      i_head,
    input  logic [1:0] i_mode,
    input  logic       i_rs,
    input  logic       i_brk,
    input  logic       i_pend,
    input  logic       i_end,
    output t_dec       o_dec
);

    logic [7:0] c;
    t_dec       d;

    assign c = i_head[0];

    always_comb begin
        d      = '0;
        d.drop = 4'd1;
        d.mode = i_mode;
        d.rs   = i_rs;
        d.brk  = i_brk;
        d.pend = i_pend;
        if (i_end) begin
            d.drop = 4'd0;
            if (i_mode == MODE_TAG) begin
                if (i_pend && !i_brk) begin
                    d.b0 = CH_NL; d.cnt = 2'd1; d.pend = 1'b0;
                end
            end else if (i_mode == MODE_RAW) begin
                if (i_pend) begin
                    d.b0 = CH_COMMA; d.b1 = CH_NL; d.cnt = 2'd2; d.pend = 1'b0;
                end
            end
            d.mode = MODE_TEXT;
            d.rs   = 1'b0;
            d.brk  = 1'b0;
        end else begin
            case (i_mode)
                MODE_TAG: begin
                    if (c == CH_GT || (c == CH_AMP && hm(i_head, "&gt;", 1'b0))) begin
                        if (c != CH_GT) d.drop = 4'd4;
                        if (i_pend && !i_brk) begin
                            d.b0 = CH_NL; d.cnt = 2'd1; d.pend = 1'b0;
                        end
                        d.mode = MODE_TEXT;
                        d.brk  = 1'b0;
                    end
                end
                MODE_RAW: begin
                    if ((i_rs && hm(i_head, "</script>", 1'b1))
                        || (!i_rs && hm(i_head, "</style>", 1'b1))) begin
                        d.drop = i_rs ? 4'd9 : 4'd8;
                        if (i_pend) begin
                            d.b0 = CH_COMMA; d.b1 = CH_NL; d.cnt = 2'd2; d.pend = 1'b0;
                        end
                        d.mode = MODE_TEXT;
                        d.rs   = 1'b0;
                    end
                end
                default: begin
                    d.mode = MODE_TEXT;
                    if (c <= CH_SPACE) begin
                        d.drop = 4'd1;
                    end else if (hm(i_head, "&nbsp;", 1'b1)) begin
                        d.drop = 4'd6;
                    end else if (hm(i_head, "&nbsp", 1'b1)) begin
                        d.drop = 4'd5;
                    end else if (hm(i_head, "&gt;", 1'b1)) begin
                        d.drop = 4'd4;
                    end else if (hm(i_head, "<styl", 1'b1)) begin
                        d.mode = MODE_RAW; d.rs = 1'b0; d.drop = 4'd5;
                    end else if (hm(i_head, "<scri", 1'b1)) begin
                        d.mode = MODE_RAW; d.rs = 1'b1; d.drop = 4'd5;
                    end else if (is_tag(i_head)) begin
                        d.mode = MODE_TAG;
                        d.brk  = hm(i_head, "<br", 1'b1) | hm(i_head, "</br", 1'b1);
                    end else begin
                        d.b0 = c; d.cnt = 2'd1; d.pend = 1'b1;
                    end
                end
            endcase
        end
    end

    assign o_dec = d;

endmodule

@@ design/htx_outq.sv @@
module htx_outq
    import htx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_wr_cnt,
    input  t_res       i_wd0,
    input  t_res       i_wd1,
    output logic       o_room,
    output logic [2:0] o_count,
    htx_out_if.source  o_out
);

    t_res       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       pop;

    assign pop             = o_out.valid && o_out.ready;
    assign o_out.valid     = (r_cnt != 3'd0);
    assign o_out.text_byte = r_mem[r_rp].data;
    assign o_out.text_last = r_mem[r_rp].last;
    assign o_room          = (r_cnt <= 3'd2);
    assign o_count         = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0) r_mem[r_wp] <= i_wd0;
        if (i_wr_cnt == 2'd2) r_mem[r_wp + 2'd1] <= i_wd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + i_wr_cnt;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, i_wr_cnt} - {2'b0, pop};
        end
    end

endmodule

@@ design/html_text_extractor.sv @@
// HTML text extractor. Raw document bytes enter a lookahead window that is
// matched in one cycle against all entity, tag and style/script patterns; the
// head byte is then emitted, dropped, or opens/closes a tag or raw block, with
// newline or ",\n" separators. Sustained rate is one byte per cycle while
// the result queue has room: one window decision is made while the next
// byte is taken in. After in_last the remaining window is drained at one
// decision per cycle while the queue has room, then an end step and a final
// step close the document, taking no byte. Results leave through a four-entry
// queue; text_last marks a document's last result if its last byte made any.
module html_text_extractor
    import htx_pkg::*;
#(
    parameter int unsigned LOOKAHEAD = 9
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    htx_in_if.sink    i_in,
    htx_out_if.source o_out
);

    localparam int unsigned FW = $clog2(LOOKAHEAD + 1);

    logic [7:0]    r_win [LOOKAHEAD];
    logic [7:0]    n_win [LOOKAHEAD];
    logic [FW-1:0] r_fill, n_fill;
    logic [1:0]    r_mode;
    logic          r_rs, r_brk, r_pend;
    logic          r_flush, r_ended;
    logic          r_hv;
    t_res          r_hold;

    t_head         head;
    t_dec          d;
    logic          q_room;
    logic [2:0]    q_count;
    logic          dec_en, end_en, fin_en, step, acc;
    logic [FW-1:0] dn;
    logic [1:0]    ecnt;
    logic [1:0]    wr_cnt;
    t_res          wd0, wd1, e0, e1;

    always_comb begin
        for (int i = 0; i < HEAD_LEN; i++) begin
            head[i] = r_win[i];
        end
    end

    htx_decide u_dec (
        .i_head (head),
        .i_mode (r_mode),
        .i_rs   (r_rs),
        .i_brk  (r_brk),
        .i_pend (r_pend),
        .i_end  (end_en),
        .o_dec  (d)
    );

    assign dec_en = q_room && !r_ended
                    && (r_fill == FW'(LOOKAHEAD) || (r_flush && r_fill != '0));
    assign end_en = q_room && r_flush && !r_ended && r_fill == '0;
    assign fin_en = q_room && r_ended;
    assign step   = dec_en || end_en;
    assign i_in.ready = !r_flush && (r_fill < FW'(LOOKAHEAD) || dec_en);
    assign acc    = i_in.valid && i_in.ready;
    assign dn     = dec_en ? FW'(d.drop) : '0;
    assign ecnt   = step ? d.cnt : 2'd0;
    assign e0     = '{data: d.b0, last: 1'b0};
    assign e1     = '{data: d.b1, last: 1'b0};

    always_comb begin
        n_fill = r_fill - dn + FW'(acc);
        for (int i = 0; i < LOOKAHEAD; i++) begin
            if (i + int'(dn) < LOOKAHEAD) n_win[i] = r_win[i + int'(dn)];
            else n_win[i] = 8'd0;
            if (acc && i == int'(r_fill - dn)) n_win[i] = i_in.in_byte;
        end
    end

    // during the flush the newest result is held back to carry text_last
    always_comb begin
        wr_cnt = 2'd0;
        wd0    = e0;
        wd1    = e1;
        if (fin_en) begin
            wr_cnt = {1'b0, r_hv};
            wd0    = '{data: r_hold.data, last: 1'b1};
        end else if (!r_flush) begin
            wr_cnt = ecnt;
        end else if (ecnt == 2'd1) begin
            wr_cnt = {1'b0, r_hv};
            wd0    = r_hold;
        end else if (ecnt == 2'd2) begin
            if (r_hv) begin
                wr_cnt = 2'd2;
                wd0    = r_hold;
                wd1    = e0;
            end else begin
                wr_cnt = 2'd1;
            end
        end
    end

    htx_outq u_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_cnt (wr_cnt),
        .i_wd0    (wd0),
        .i_wd1    (wd1),
        .o_room   (q_room),
        .o_count  (q_count),
        .o_out    (o_out)
    );

    always_ff @(posedge i_clk) begin
        if (r_flush && ecnt == 2'd1) r_hold <= e0;
        else if (r_flush && ecnt == 2'd2) r_hold <= e1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LOOKAHEAD; i++) r_win[i] <= 8'd0;
            r_fill  <= '0;
            r_mode  <= MODE_TEXT;
            r_rs    <= 1'b0;
            r_brk   <= 1'b0;
            r_pend  <= 1'b0;
            r_flush <= 1'b0;
            r_ended <= 1'b0;
            r_hv    <= 1'b0;
        end else begin
            r_win  <= n_win;
            r_fill <= n_fill;
            if (step) begin
                r_mode <= d.mode;
                r_rs   <= d.rs;
                r_brk  <= d.brk;
                r_pend <= d.pend;
            end
            if (acc && i_in.in_last) r_flush <= 1'b1;
            if (end_en) r_ended <= 1'b1;
            if (r_flush && ecnt != 2'd0) r_hv <= 1'b1;
            if (fin_en) begin
                r_mode  <= MODE_TEXT;
                r_rs    <= 1'b0;
                r_brk   <= 1'b0;
                r_pend  <= 1'b0;
                r_flush <= 1'b0;
                r_ended <= 1'b0;
                r_hv    <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(LOOKAHEAD))
        else $error("window fill out of range");
    a_no_acc_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> !acc)
        else $error("request taken during flush");
    a_hold_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hv |-> r_flush)
        else $error("held result outside flush");
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= 3'd4)
        else $error("result queue overflow");
`endif

endmodule

@@ bench/tb_html_text_extractor.sv @@
`timescale 1ns / 1ps

module tb_html_text_extractor;
    import htx_pkg::*;

    localparam int unsigned WIN = 9;
    localparam int unsigned STALL_LIMIT = 20000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_req;

    logic i_clk;
    logic i_rst_n;

    htx_in_if  in_ch ();
    htx_out_if out_ch ();

    html_text_extractor #(.LOOKAHEAD(WIN)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // predictor state
    logic [7:0] win_q [WIN];
    int unsigned fill_q;
    logic [1:0]  mode_q;
    logic        script_q;
    logic        brk_q;
    logic        pend_q;
    t_res        step_res [$];

    t_req  pending_reqs [$];
    t_res  expected_text [$];
    int    mismatches;
    bit    hold_sender;
    bit    no_idle;
    int    rx_hold;
    int    idle_cycles;

    function automatic bit pat_match(string p, bit f);
        logic [7:0] c;
        for (int i = 0; i < p.len(); i++) begin
            if (i >= fill_q) return 1'b0;
            c = win_q[i];
            if (f && c >= "A" && c <= "Z") c = c + 8'd32;
            if (c != p[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit opens_tag();
        string tags[$];
        tags = '{"&lt;", "<u", "<s", "<b", "<h", "<a", "<p", "<!", "<i", "<d",
            "<pre", "<mar", "<frame", "<no", "<map", "<th", "<text", "<lay", "<li",
            "<opti", "<tbody", "<objec", "<embed", "<meta", "<titl", "<font",
            "<tabl", "<cent", "<form", "<tr", "<td", "<em", "<labe",
            "</u", "</s", "</b", "</a", "</p", "</i", "</d", "</h", "</no",
            "</pre", "</mar", "</map", "</lay", "</li", "</th", "</tex", "</opt",
            "</tbod", "</obje", "</embe", "</meta", "</titl", "</font", "</tabl",
            "</cent", "</form", "</tr", "</td", "</em", "</labe"};
        foreach (tags[i]) if (pat_match(tags[i], 1'b1)) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void emit(logic [7:0] b);
        if (step_res.size() < 16) step_res.push_back('{data: b, last: 1'b0});
    endfunction

    function automatic void shift_out(int unsigned n);
        if (n > fill_q) n = fill_q;
        for (int i = 0; i < WIN; i++) win_q[i] = (i + n < WIN) ? win_q[i + n] : 8'h00;
        fill_q -= n;
    endfunction

    function automatic void close_tag();
        if (pend_q && !brk_q) begin
            emit(CH_NL);
            pend_q = 1'b0;
        end
        mode_q = MODE_TEXT;
        brk_q  = 1'b0;
    endfunction

    function automatic void close_raw();
        if (pend_q) begin
            emit(CH_COMMA);
            emit(CH_NL);
            pend_q = 1'b0;
        end
        mode_q   = MODE_TEXT;
        script_q = 1'b0;
    endfunction

    function automatic void classify_head();
        logic [7:0] c;
        c = win_q[0];
        if (mode_q == MODE_TAG) begin
            if (c == CH_GT) begin close_tag(); shift_out(1); end
            else if (c == CH_AMP && pat_match("&gt;", 1'b0)) begin
                close_tag(); shift_out(4);
            end else shift_out(1);
            return;
        end
        if (mode_q == MODE_RAW) begin
            if (script_q && pat_match("</script>", 1'b1)) begin close_raw(); shift_out(9); end
            else if (!script_q && pat_match("</style>", 1'b1)) begin
                close_raw(); shift_out(8);
            end else shift_out(1);
            return;
        end
        mode_q = MODE_TEXT;
        if (c <= CH_SPACE) shift_out(1);
        else if (pat_match("&nbsp;", 1'b1)) shift_out(6);
        else if (pat_match("&nbsp", 1'b1)) shift_out(5);
        else if (pat_match("&gt;", 1'b1)) shift_out(4);
        else if (pat_match("<styl", 1'b1)) begin
            mode_q = MODE_RAW; script_q = 1'b0; shift_out(5);
        end else if (pat_match("<scri", 1'b1)) begin
            mode_q = MODE_RAW; script_q = 1'b1; shift_out(5);
        end else if (opens_tag()) begin
            mode_q = MODE_TAG;
            brk_q  = pat_match("<br", 1'b1) || pat_match("</br", 1'b1);
            shift_out(1);
        end else begin
            emit(c);
            pend_q = 1'b1;
            shift_out(1);
        end
    endfunction

    function automatic void clear_extractor();
        foreach (win_q[i]) win_q[i] = 8'h00;
        fill_q = 0; mode_q = MODE_TEXT; script_q = 0; brk_q = 0; pend_q = 0;
    endfunction

    function automatic void predict_text(t_req r);
        step_res.delete();
        while (fill_q >= WIN) classify_head();
        win_q[fill_q] = r.data;
        fill_q++;
        while (fill_q >= WIN) classify_head();
        if (r.last) begin
            while (fill_q > 0) classify_head();
            if (mode_q == MODE_TAG) close_tag();
            else if (mode_q == MODE_RAW) close_raw();
            if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
            clear_extractor();
        end
        foreach (step_res[i]) expected_text.push_back(step_res[i]);
    endfunction

    function automatic bit one_in(int n);
        return !no_idle && ($urandom_range(99) < n);
    endfunction

    task automatic queue_str(string s, bit last_at_end);
        for (int i = 0; i < s.len(); i++)
            pending_reqs.push_back('{data: s[i], last: last_at_end && i == s.len() - 1});
    endtask

    function automatic string rand_doc();
        string pieces[$];
        string s;
        int n;
        pieces = '{"Hello", "<p>", "</P>", "<BR>", "</br>", "&nbsp;", "&nbsp", "&gt;",
            "&lt;x&gt;", "<Style>a{}</STYLE>", "<script>x<y</script>", "<div class=q>",
            " ", "\n", "text ", "<!-- c -->", "<TABLE>", "<td>", "Zz9", "<zz>", "&amp;"};
        s = "";
        n = $urandom_range(1, 8);
        repeat (n) begin
            if ($urandom_range(9) < 2) begin
                s = {s, string'(8'($urandom_range(1, 255)))};
            end else s = {s, pieces[$urandom_range(pieces.size() - 1)]};
        end
        return s;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.in_byte <= 8'h00;
            in_ch.in_last <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) predict_text('{data: in_ch.in_byte, last: in_ch.in_last});
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_reqs.size() > 0 && !hold_sender && !one_in(10)) begin
                    in_ch.valid   <= 1'b1;
                    in_ch.in_byte <= pending_reqs[0].data;
                    in_ch.in_last <= pending_reqs[0].last;
                    void'(pending_reqs.pop_front());
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_text.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h last=%b", out_ch.text_byte, out_ch.text_last);
                end else begin
                    if (out_ch.text_byte !== expected_text[0].data
                        || out_ch.text_last !== expected_text[0].last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h/%b got %h/%b", expected_text[0].data,
                                expected_text[0].last, out_ch.text_byte, out_ch.text_last);
                    end
                    void'(expected_text.pop_front());
                end
            end
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !one_in(10);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_ch.valid || expected_text.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        string s;
        int items;
        mismatches = 0; rx_hold = 0; hold_sender = 0; no_idle = 0; idle_cycles = 0;
        clear_extractor();
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0; in_ch.in_byte = 8'h00; in_ch.in_last = 1'b0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: entities, tags, br, raw blocks, high bytes, cut patterns
        queue_str("Ab<p>c&NBSP;d&nbspe&gt;f<BR>g</br>h&lt;i&gt;j", 1'b0);
        queue_str("<STYLE>zz</style>k<scRIpt>q</SCRIPT>", 1'b0);
        pending_reqs.push_back('{data: 8'hFF, last: 1'b0});
        pending_reqs.push_back('{data: 8'h80, last: 1'b0});
        pending_reqs.push_back('{data: 8'h00, last: 1'b0});
        pending_reqs.push_back('{data: 8'h7F, last: 1'b0});
        queue_str("x<b", 1'b1);
        queue_str("<td>", 1'b1);
        queue_str("m<script>abc", 1'b1);
        queue_str("&nb", 1'b1);
        pending_reqs.push_back('{data: 8'h41, last: 1'b1});
        wait_drained();

        // pause sender while a document is queued, then release it and wait until drained
        hold_sender = 1;
        queue_str("Text<p>more", 1'b1);
        repeat (20) @(posedge i_clk);
        hold_sender = 0;
        wait_drained();

        // long receiver hold-off
        rx_hold = 300;
        no_idle = 1;
        items = 0;
        while (items < 100) begin
            s = rand_doc();
            if (items > 80) no_idle = 0;
            queue_str(s, $urandom_range(3) == 0);
            items += s.len();
        end
        queue_str("end", 1'b1);
        wait_drained();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && expected_text.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
